// ===== rtl/core/epg_pkg.sv =====
// Shared types, register map and phase codes of the ESC pulse generator.
`timescale 1ns / 1ps
package epg_pkg;

	localparam int CHANNELS = 4;
	localparam int USED_CH  = (CHANNELS > 4) ? 4 : CHANNELS;
	localparam logic [3:0] CH_MASK = 4'((1 << USED_CH) - 1);

	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_OFFSET = 3'd0;
	localparam logic [2:0] REG_UNIT   = 3'd1;
	localparam logic [2:0] REG_WINDOW = 3'd2;
	localparam logic [2:0] REG_GAP    = 3'd3;
	localparam logic [2:0] REG_MAX    = 3'd4;

	localparam logic [11:0] OFFSET_RST = 12'd1160;
	localparam logic [7:0]  UNIT_RST   = 8'd4;
	localparam logic [7:0]  WINDOW_RST = 8'd220;
	localparam logic [11:0] GAP_RST    = 12'd10;
	localparam logic [7:0]  MAX_RST    = 8'd200;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_OFFSET = 2'd1;
	localparam logic [1:0] PH_WINDOW = 2'd2;
	localparam logic [1:0] PH_GAP    = 2'd3;

	typedef struct packed {
		logic [11:0] offset_ticks;
		logic [7:0]  unit_ticks;
		logic [7:0]  window_units;
		logic [11:0] gap_ticks;
		logic [7:0]  max_value;
	} epg_cfg_t;

	typedef struct packed {
		logic               command;
		logic signed [15:0] motor_one;
		logic signed [15:0] motor_two;
		logic signed [15:0] motor_three;
		logic signed [15:0] motor_four;
		logic               armed;
	} epg_in_t;

	typedef struct packed {
		logic [3:0] pin_levels;
		logic       busy_res;
		logic       frame_done;
		logic       rejected;
	} epg_out_t;

	// negative commands go to zero, large ones to the clamp
	function automatic logic [7:0] clamp_cmd(input logic [15:0] raw, input logic [7:0] max_v);
		logic [7:0] res;
		if (raw[15])
			res = 8'd0;
		else if (raw[14:0] > {7'd0, max_v})
			res = max_v;
		else
			res = raw[7:0];
		return res;
	endfunction

endpackage

// ===== rtl/core/epg_regs.sv =====
// APB configuration registers of the ESC pulse generator.
`timescale 1ns / 1ps
module epg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [epg_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output epg_pkg::epg_cfg_t          cfg
);

	epg_pkg::epg_cfg_t cfg_q;
	logic              wr_en;
	logic [2:0]        reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[epg_pkg::ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_ticks <= epg_pkg::OFFSET_RST;
			cfg_q.unit_ticks   <= epg_pkg::UNIT_RST;
			cfg_q.window_units <= epg_pkg::WINDOW_RST;
			cfg_q.gap_ticks    <= epg_pkg::GAP_RST;
			cfg_q.max_value    <= epg_pkg::MAX_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				epg_pkg::REG_OFFSET: cfg_q.offset_ticks <= pwdata[11:0];
				epg_pkg::REG_UNIT:   cfg_q.unit_ticks   <= pwdata[7:0];
				epg_pkg::REG_WINDOW: cfg_q.window_units <= pwdata[7:0];
				epg_pkg::REG_GAP:    cfg_q.gap_ticks    <= pwdata[11:0];
				epg_pkg::REG_MAX:    cfg_q.max_value    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			epg_pkg::REG_OFFSET: prdata = {20'd0, cfg_q.offset_ticks};
			epg_pkg::REG_UNIT:   prdata = {24'd0, cfg_q.unit_ticks};
			epg_pkg::REG_WINDOW: prdata = {24'd0, cfg_q.window_units};
			epg_pkg::REG_GAP:    prdata = {20'd0, cfg_q.gap_ticks};
			epg_pkg::REG_MAX:    prdata = {24'd0, cfg_q.max_value};
			default:             prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/core/epg_core.sv =====
// Frame sequencer: phase, tick and unit counters, latched values, pin state.
`timescale 1ns / 1ps
module epg_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  epg_pkg::epg_in_t  item,
	input  epg_pkg::epg_cfg_t cfg,
	output epg_pkg::epg_out_t res
);

	logic [1:0]  phase_q,  phase_d;
	logic [11:0] tick_q,   tick_d;
	logic [7:0]  unit_q,   unit_d;
	logic [3:0]  pins_q,   pins_d;
	logic [7:0]  latch_q [4];
	logic [7:0]  latch_d [4];
	logic [11:0] tick_inc;
	logic [7:0]  unit_inc;
	logic        done;
	logic        rej;

	assign tick_inc = tick_q + 12'd1;
	assign unit_inc = unit_q + 8'd1;

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		unit_d  = unit_q;
		pins_d  = pins_q;
		latch_d = latch_q;
		done    = 1'b0;
		rej     = 1'b0;
		if (item.command) begin
			if (phase_q == epg_pkg::PH_IDLE && item.armed) begin
				latch_d[0] = epg_pkg::clamp_cmd(item.motor_one,   cfg.max_value);
				latch_d[1] = epg_pkg::clamp_cmd(item.motor_two,   cfg.max_value);
				latch_d[2] = epg_pkg::clamp_cmd(item.motor_three, cfg.max_value);
				latch_d[3] = epg_pkg::clamp_cmd(item.motor_four,  cfg.max_value);
				pins_d  = epg_pkg::CH_MASK;
				tick_d  = 12'd0;
				unit_d  = 8'd0;
				phase_d = (cfg.offset_ticks == 12'd0) ? epg_pkg::PH_WINDOW
				                                      : epg_pkg::PH_OFFSET;
			end else begin
				rej = 1'b1;
			end
		end else begin
			unique case (phase_q)
				epg_pkg::PH_OFFSET: begin
					tick_d = tick_inc;
					if (tick_inc >= cfg.offset_ticks) begin
						tick_d  = 12'd0;
						unit_d  = 8'd0;
						phase_d = epg_pkg::PH_WINDOW;
					end
				end
				epg_pkg::PH_WINDOW: begin
					tick_d = tick_inc;
					// zero unit length behaves as one: the compare always passes
					if (tick_inc >= {4'd0, cfg.unit_ticks}) begin
						tick_d = 12'd0;
						for (int n = 0; n < epg_pkg::USED_CH; n++) begin
							if (latch_q[n] == unit_q)
								pins_d[n] = 1'b0;
						end
						unit_d = unit_inc;
						if (unit_inc >= cfg.window_units || unit_inc == 8'd0) begin
							pins_d = 4'd0;
							unit_d = 8'd0;
							if (cfg.gap_ticks == 12'd0) begin
								phase_d = epg_pkg::PH_IDLE;
								done    = 1'b1;
							end else begin
								phase_d = epg_pkg::PH_GAP;
							end
						end
					end
				end
				epg_pkg::PH_GAP: begin
					tick_d = tick_inc;
					if (tick_inc >= cfg.gap_ticks) begin
						tick_d  = 12'd0;
						phase_d = epg_pkg::PH_IDLE;
						done    = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign res.pin_levels = pins_d;
	assign res.busy_res   = (phase_d != epg_pkg::PH_IDLE);
	assign res.frame_done = done;
	assign res.rejected   = rej;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= epg_pkg::PH_IDLE;
			tick_q  <= 12'd0;
			unit_q  <= 8'd0;
			pins_q  <= 4'd0;
			for (int n = 0; n < 4; n++)
				latch_q[n] <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			unit_q  <= unit_d;
			pins_q  <= pins_d;
			latch_q <= latch_d;
		end
	end

endmodule

// ===== rtl/core/esc_pulse_generator.sv =====
// Top level of the ESC pulse generator: input register, sequencer, result register.
// The input register feeds the sequencer, whose result loads the result register.
// One item per cycle unless the output stalls; the sequencer updates once per item.
// The input register refills in the cycle the result register is loaded or taken.
// Reset (arst_n low) empties both registers, sets the phase idle with pins low,
// and loads the register defaults.
`timescale 1ns / 1ps
module esc_pulse_generator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  epg_pkg::epg_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output epg_pkg::epg_out_t          out_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [epg_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	epg_pkg::epg_cfg_t cfg;
	epg_pkg::epg_in_t  item_s1;
	epg_pkg::epg_out_t res;
	epg_pkg::epg_out_t out_q;
	logic              valid_s1;
	logic              out_valid_q;
	logic              load;

	assign load      = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready  = ~valid_s1 | load;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	epg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	epg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (load),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= res;
	end

endmodule

// ===== rtl/core/epg_checker.sv =====
// Port-level checks of the ESC pulse generator, bound to the top level.
`timescale 1ns / 1ps
module epg_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input epg_pkg::epg_out_t out_data
);

	logic out_xfer;
	assign out_xfer = out_valid & out_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && out_data.frame_done |-> !out_data.busy_res && out_data.pin_levels == 4'd0)
		else $error("frame end left the block busy or a pin high");

	a_idle_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !out_data.busy_res |-> out_data.pin_levels == 4'd0)
		else $error("pin high while idle");

	a_rej_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && out_data.rejected |-> !out_data.frame_done)
		else $error("rejected request also ended a frame");

endmodule

bind esc_pulse_generator epg_checker u_epg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== tb/esc_pulse_generator_test.sv =====
// Self-checking testbench for the ESC pulse generator: directed frames, then random frames.
`timescale 1ns / 1ps
module esc_pulse_generator_test;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_REQ  = 1'b1;
	localparam int STALL_LIMIT = 4000;
	localparam int RAND_PHASES = 8;
	localparam int RAND_ITEMS  = 280;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	epg_pkg::epg_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	epg_pkg::epg_out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [epg_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// no random idling on either side while set
	logic calm = 1'b0;

	epg_pkg::epg_in_t pending_cmds[$];
	epg_pkg::epg_out_t expected_pins[$];
	int errors = 0;
	int results_seen = 0;
	int stall_cycles = 0;

	// shadow registers
	logic [11:0] c_offset;
	logic [7:0]  c_unit;
	logic [7:0]  c_window;
	logic [11:0] c_gap;
	logic [7:0]  c_max;

	// shadow sequencer state
	logic [1:0]  ph;
	logic [11:0] tick_cnt;
	logic [7:0]  unit_idx;
	logic [7:0]  lat_val[4];
	logic [3:0]  pins_now;

	esc_pulse_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	function automatic logic [7:0] limit_cmd(input logic signed [15:0] raw);
		int v;
		v = raw;
		if (v < 0)
			return 8'd0;
		if (v > int'(c_max))
			return c_max;
		return v[7:0];
	endfunction

	function automatic epg_pkg::epg_out_t advance_pulse(input epg_pkg::epg_in_t it);
		epg_pkg::epg_out_t r;
		logic done;
		logic rej;
		done = 1'b0;
		rej = 1'b0;
		if (it.command == CMD_REQ) begin
			if (ph == epg_pkg::PH_IDLE && it.armed) begin
				lat_val[0] = limit_cmd(it.motor_one);
				lat_val[1] = limit_cmd(it.motor_two);
				lat_val[2] = limit_cmd(it.motor_three);
				lat_val[3] = limit_cmd(it.motor_four);
				pins_now = epg_pkg::CH_MASK;
				tick_cnt = '0;
				unit_idx = '0;
				ph = (c_offset == 0) ? epg_pkg::PH_WINDOW : epg_pkg::PH_OFFSET;
			end else begin
				rej = 1'b1;
			end
		end else begin
			case (ph)
				epg_pkg::PH_OFFSET: begin
					tick_cnt = tick_cnt + 12'd1;
					if (tick_cnt >= c_offset) begin
						tick_cnt = '0;
						unit_idx = '0;
						ph = epg_pkg::PH_WINDOW;
					end
				end
				epg_pkg::PH_WINDOW: begin
					tick_cnt = tick_cnt + 12'd1;
					// zero unit length acts as one tick per unit
					if (tick_cnt >= {4'd0, c_unit}) begin
						tick_cnt = '0;
						for (int n = 0; n < epg_pkg::USED_CH; n++)
							if (lat_val[n] == unit_idx)
								pins_now[n] = 1'b0;
						unit_idx = unit_idx + 8'd1;
						if (unit_idx >= c_window || unit_idx == 8'd0) begin
							pins_now = '0;
							unit_idx = '0;
							if (c_gap == 0) begin
								ph = epg_pkg::PH_IDLE;
								done = 1'b1;
							end else begin
								ph = epg_pkg::PH_GAP;
							end
						end
					end
				end
				epg_pkg::PH_GAP: begin
					tick_cnt = tick_cnt + 12'd1;
					if (tick_cnt >= c_gap) begin
						tick_cnt = '0;
						ph = epg_pkg::PH_IDLE;
						done = 1'b1;
					end
				end
				default: ;
			endcase
		end
		r.pin_levels = pins_now;
		r.busy_res = (ph != epg_pkg::PH_IDLE);
		r.frame_done = done;
		r.rejected = rej;
		return r;
	endfunction

	// ticks from request to frame end under the current register set
	function automatic int frame_ticks();
		int u;
		int w;
		u = (c_unit == 0) ? 1 : int'(c_unit);
		w = (c_window == 0) ? 1 : int'(c_window);
		return int'(c_offset) + u * w + int'(c_gap);
	endfunction

	function automatic logic signed [15:0] rand_motor();
		logic signed [15:0] v;
		case ($urandom_range(0, 9))
			6: v = 16'($urandom);
			7: v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			8: v = $signed({8'd0, c_max}) + $signed(16'($urandom_range(0, 1)));
			9: v = -$signed(16'($urandom_range(1, 300)));
			default: v = 16'($urandom_range(0, int'(c_window) + 2));
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 40)
			$display("mismatch at result %0d: %s", results_seen, what);
	endtask

	task automatic push_item(input logic cmd, input logic arm, input logic signed [15:0] m1,
			input logic signed [15:0] m2, input logic signed [15:0] m3,
			input logic signed [15:0] m4);
		epg_pkg::epg_in_t it;
		it.command = cmd;
		it.armed = arm;
		it.motor_one = m1;
		it.motor_two = m2;
		it.motor_three = m3;
		it.motor_four = m4;
		pending_cmds.push_back(it);
	endtask

	// motor and armed fields are don't-care on ticks, so they carry noise
	task automatic push_ticks(input int count);
		for (int i = 0; i < count; i++)
			push_item(CMD_TICK, 1'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom));
	endtask

	task automatic push_request(input logic arm);
		push_item(CMD_REQ, arm, rand_motor(), rand_motor(), rand_motor(), rand_motor());
	endtask

	// one frame with random content, sometimes a busy request inside; or an unarmed request, or noise
	task automatic push_frame_seq(output int counted);
		int len;
		int cut;
		int roll;
		len = frame_ticks();
		roll = $urandom_range(0, 99);
		counted = 0;
		if (roll < 12) begin
			for (int i = $urandom_range(1, 3); i > 0; i--)
				push_item(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
		end else if (roll < 20) begin
			push_request(1'b0);
		end else begin
			push_request(1'b1);
			counted = 1 + len;
			if ($urandom_range(0, 4) == 0) begin
				cut = $urandom_range(0, len - 1);
				push_ticks(cut);
				push_request(1'($urandom));
				push_ticks(len - cut);
			end else begin
				push_ticks(len);
			end
			if ($urandom_range(0, 3) == 0)
				push_ticks($urandom_range(1, 3));
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			epg_pkg::REG_OFFSET: c_offset = val[11:0];
			epg_pkg::REG_UNIT:   c_unit = val[7:0];
			epg_pkg::REG_WINDOW: c_window = val[7:0];
			epg_pkg::REG_GAP:    c_gap = val[11:0];
			epg_pkg::REG_MAX:    c_max = val[7:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input int o, input int u, input int w, input int g, input int m);
		write_reg(epg_pkg::REG_OFFSET, o);
		write_reg(epg_pkg::REG_UNIT, u);
		write_reg(epg_pkg::REG_WINDOW, w);
		write_reg(epg_pkg::REG_GAP, g);
		write_reg(epg_pkg::REG_MAX, m);
	endtask

	// hold off until every transfer has come back, then let the pipeline drain
	task automatic settle();
		while (pending_cmds.size() != 0 || in_valid || expected_pins.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// driver: one transfer per free slot unless idling this cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_pins.push_back(advance_pulse(in_data));
			if (!in_valid || in_ready) begin
				if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 34)) begin
					in_data <= pending_cmds.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= calm || ($urandom_range(0, 99) >= 34);
	end

	// monitor
	always @(posedge clk) begin
		epg_pkg::epg_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pins.size() == 0) begin
				report_mismatch("result with nothing outstanding");
			end else begin
				want = expected_pins.pop_front();
				if (out_data.pin_levels !== want.pin_levels)
					report_mismatch($sformatf("pin_levels %h, want %h",
						out_data.pin_levels, want.pin_levels));
				if (out_data.busy_res !== want.busy_res)
					report_mismatch($sformatf("busy_res %b, want %b",
						out_data.busy_res, want.busy_res));
				if (out_data.frame_done !== want.frame_done)
					report_mismatch($sformatf("frame_done %b, want %b",
						out_data.frame_done, want.frame_done));
				if (out_data.rejected !== want.rejected)
					report_mismatch($sformatf("rejected %b, want %b",
						out_data.rejected, want.rejected));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int counted;
		int got;
		int target;
		c_offset = 12'd1160;
		c_unit = 8'd4;
		c_window = 8'd220;
		c_gap = 12'd10;
		c_max = 8'd200;
		ph = epg_pkg::PH_IDLE;
		tick_cnt = '0;
		unit_idx = '0;
		pins_now = '0;
		for (int n = 0; n < 4; n++)
			lat_val[n] = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults: idle ticks, unarmed request, frame start with a busy request
		push_ticks(2);
		push_item(CMD_REQ, 1'b0, 16'sd100, 16'sd100, 16'sd100, 16'sd100);
		push_item(CMD_REQ, 1'b1, -16'sd5, 16'sd0, 16'sd200, 16'sh7FFF);
		push_ticks(30);
		push_item(CMD_REQ, 1'b1, 16'sd3, 16'sd3, 16'sd3, 16'sd3);
		push_ticks(2);
		settle();

		// zero offset, zero unit and window lengths, zero gap; the open frame ends first
		write_all(0, 0, 0, 0, 255);
		push_ticks(3);
		push_item(CMD_REQ, 1'b1, 16'sd0, 16'sd1, 16'sd255, 16'sh8000);
		push_ticks(2);
		push_item(CMD_REQ, 1'b1, 16'sh7FFF, -16'sd1, 16'sd0, 16'sd300);
		push_ticks(2);
		settle();

		// widest unit, every command clamped to zero
		write_all(5, 255, 1, 5, 0);
		push_item(CMD_REQ, 1'b1, 16'sh7FFF, 16'sd1, -16'sd1, 16'sd0);
		push_ticks(frame_ticks() + 1);
		settle();

		// widest window, values on and beyond its last unit, no idling
		calm <= 1'b1;
		write_all(1, 1, 255, 1, 255);
		push_item(CMD_REQ, 1'b1, 16'sd254, 16'sd255, 16'sd128, 16'sd0);
		push_ticks(frame_ticks() + 1);
		settle();
		calm <= 1'b0;

		got = 0;
		for (int p = 0; p < RAND_PHASES; p++) begin
			calm <= (p == 4);
			write_all($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6),
				$urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3),
				$urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 12),
				$urandom_range(0, 4),
				$urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 14));
			target = (p + 1) * RAND_ITEMS / RAND_PHASES;
			while (got < target) begin
				push_frame_seq(counted);
				got += counted;
			end
			settle();
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
